FILE: hw/rtl/rmst_pkg.sv
// Shared types, constants and helpers for the 2D range-max sparse table.
package rmst_pkg;
  localparam int MaxRows    = 32;
  localparam int MaxCols    = 32;
  localparam int Levels     = 6;
  localparam int ValueWidth = 32;
  localparam int RowW  = $clog2(MaxRows);
  localparam int ColW  = $clog2(MaxCols);
  localparam int LvlW  = $clog2(Levels);
  localparam int CntW  = 6;
  localparam int Depth = Levels * Levels * MaxRows * MaxCols;
  localparam int AddrW = $clog2(Depth);

  localparam logic [1:0] KindLoad  = 2'd0;
  localparam logic [1:0] KindBuild = 2'd1;
  localparam logic [1:0] KindQuery = 2'd2;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusInvalid = 2'd1;
  localparam logic [1:0] StatusBuilt   = 2'd2;

  localparam logic CfgRowCount = 1'b0;
  localparam logic CfgColCount = 1'b1;

  typedef enum logic [1:0] {
    SelQa = 2'd0,
    SelQb = 2'd1,
    SelQc = 2'd2,
    SelQd = 2'd3
  } qsel_e;

  // Memory address operation chosen by the controller.
  typedef enum logic [2:0] {
    AopLoad  = 3'd0,
    AopQuery = 3'd1,
    AopSrcX  = 3'd2,
    AopSrcY  = 3'd3,
    AopDst   = 3'd4
  } aop_e;

  typedef struct packed {
    logic        latch_req;
    logic        mem_rd;
    logic        mem_wr;
    aop_e        aop;
    qsel_e       qsel;
    logic        cap_x;
    logic        cap_y;
    logic        acc_init;
    logic        acc_upd;
    logic        walk_init;
    logic        walk_step;
    logic        out_load;
    logic [1:0]  out_status;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        load_ok;
    logic        query_ok;
    logic        walk_skip;
    logic        walk_last;
    logic        walk_done;
  } dp_sts_t;

  function automatic logic [LvlW-1:0] floor_log2(input logic [CntW-1:0] v);
    logic [LvlW-1:0] r;
    r = '0;
    for (int b = 0; b < CntW; b++) begin
      if (v[b]) r = LvlW'(b);
    end
    if (r > LvlW'(Levels - 1)) r = LvlW'(Levels - 1);
    return r;
  endfunction

  function automatic logic [AddrW-1:0] slot(input logic [LvlW-1:0] p,
      input logic [LvlW-1:0] q, input logic [RowW-1:0] i,
      input logic [ColW-1:0] j);
    logic [AddrW-1:0] pq;
    pq = AddrW'(p) * AddrW'(Levels) + AddrW'(q);
    return AddrW'({pq[AddrW-RowW-ColW-1:0], i, j});
  endfunction
endpackage

FILE: hw/rtl/range_max_2d_sparse_table.sv
// Top level of the 2D range-maximum sparse table block.
// Usage:
//  - s_axis carries requests; tdata = row_a, col_a, row_b, col_b, element from the
//    low bit up, tuser = kind (0 load, 1 build, 2 query).
//  - m_axis carries results; tdata = max_value, tuser = status.
//  - cfg_we_i/cfg_idx_i/cfg_data_i write row_count (0) and col_count (1) while idle.
// Sequencing: one request at a time. A load gives no result. A query makes four reads
// of the single-port table memory in series; an invalid query skips the reads. A build
// walks every level entry, writing each entry of a fitting level and stepping over
// skipped levels, then gives a result with status 2.
// Reset: sizes return to 32x32; the table memory keeps stale contents and
// must be loaded and built before queries.
// Stall: the result waits in an output register; a new request is taken only
// once that register is free.
module range_max_2d_sparse_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // row_a, col_a, row_b, col_b, element
  input  logic [1:0]  s_axis_tuser,  // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // max_value
  output logic [1:0]  m_axis_tuser,  // status
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [5:0]  cfg_data_i
);
  rmst_pkg::dp_cmd_t cmd;
  rmst_pkg::dp_sts_t sts;
  logic out_busy;

  // A result still waiting blocks the next request.
  assign out_busy = m_axis_tvalid && !m_axis_tready;

  rmst_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .out_busy_i  (out_busy),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rmst_datapath u_dp (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .kind_i      (s_axis_tuser),
    .row_a_i     (s_axis_tdata[4:0]),
    .col_a_i     (s_axis_tdata[9:5]),
    .row_b_i     (s_axis_tdata[14:10]),
    .col_b_i     (s_axis_tdata[19:15]),
    .element_i   (s_axis_tdata[51:20]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .max_value_o (m_axis_tdata),
    .status_o    (m_axis_tuser)
  );
endmodule

FILE: hw/rtl/rmst_ctrl.sv
// Controller sequencing loads, the level build walk and four-read queries.
module rmst_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  logic              out_busy_i,
  input  rmst_pkg::dp_sts_t sts_i,
  output rmst_pkg::dp_cmd_t cmd_o
);
  typedef enum logic [9:0] {
    StIdle  = 10'b0000000001,
    StDec   = 10'b0000000010,
    StQa    = 10'b0000000100,
    StQb    = 10'b0000001000,
    StQc    = 10'b0000010000,
    StQd    = 10'b0000100000,
    StQe    = 10'b0001000000,
    StBx    = 10'b0010000000,
    StBy    = 10'b0100000000,
    StBw    = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic   flush_q, flush_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      flush_q <= 1'b0;
    end else begin
      state_q <= state_d;
      flush_q <= flush_d;
    end
  end

  assign req_ready_o = (state_q == StIdle) && !out_busy_i;

  always_comb begin
    state_d = state_q;
    flush_d = 1'b0;
    cmd_o = '0;
    cmd_o.aop = rmst_pkg::AopLoad;
    cmd_o.qsel = rmst_pkg::SelQa;
    unique case (state_q)
      StIdle: begin
        if (req_valid_i && !out_busy_i) begin
          cmd_o.latch_req = 1'b1;
          state_d = StDec;
        end
      end
      StDec: begin
        unique case (sts_i.kind)
          rmst_pkg::KindLoad: begin
            cmd_o.aop = rmst_pkg::AopLoad;
            cmd_o.mem_wr = sts_i.load_ok;
            state_d = StIdle;
          end
          rmst_pkg::KindBuild: begin
            cmd_o.walk_init = 1'b1;
            state_d = StBx;
          end
          rmst_pkg::KindQuery: begin
            if (sts_i.query_ok) begin
              cmd_o.aop = rmst_pkg::AopQuery;
              cmd_o.qsel = rmst_pkg::SelQa;
              cmd_o.mem_rd = 1'b1;
              state_d = StQa;
            end else begin
              cmd_o.out_load = 1'b1;
              cmd_o.out_status = rmst_pkg::StatusInvalid;
              state_d = StIdle;
            end
          end
          default: state_d = StIdle;
        endcase
      end
      // Each read lands in rd_q in the cycle after the one that issues it.
      StQa: begin
        cmd_o.acc_init = 1'b1;
        cmd_o.aop = rmst_pkg::AopQuery;
        cmd_o.qsel = rmst_pkg::SelQb;
        cmd_o.mem_rd = 1'b1;
        state_d = StQb;
      end
      StQb: begin
        cmd_o.acc_upd = 1'b1;
        cmd_o.aop = rmst_pkg::AopQuery;
        cmd_o.qsel = rmst_pkg::SelQc;
        cmd_o.mem_rd = 1'b1;
        state_d = StQc;
      end
      StQc: begin
        cmd_o.acc_upd = 1'b1;
        cmd_o.aop = rmst_pkg::AopQuery;
        cmd_o.qsel = rmst_pkg::SelQd;
        cmd_o.mem_rd = 1'b1;
        state_d = StQd;
      end
      StQd: begin
        cmd_o.acc_upd = 1'b1;
        state_d = StQe;
      end
      StQe: begin
        cmd_o.acc_upd = 1'b1;
        cmd_o.out_load = 1'b1;
        cmd_o.out_status = rmst_pkg::StatusOk;
        state_d = StIdle;
      end
      // Build walk: read source x, read source y, then write the maximum.
      StBx: begin
        if (sts_i.walk_done) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_status = rmst_pkg::StatusBuilt;
          state_d = StIdle;
        end else if (sts_i.walk_skip) begin
          cmd_o.walk_step = 1'b1;
        end else begin
          cmd_o.aop = rmst_pkg::AopSrcX;
          cmd_o.mem_rd = 1'b1;
          state_d = StBy;
        end
      end
      StBy: begin
        cmd_o.cap_x = 1'b1;
        cmd_o.aop = rmst_pkg::AopSrcY;
        cmd_o.mem_rd = 1'b1;
        state_d = StBw;
      end
      StBw: begin
        if (!flush_q) begin
          flush_d = 1'b1;
        end else begin
          cmd_o.cap_y = 1'b1;
          cmd_o.aop = rmst_pkg::AopDst;
          cmd_o.mem_wr = 1'b1;
          cmd_o.walk_step = 1'b1;
          state_d = StBx;
        end
      end
      default: state_d = StIdle;
    endcase
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_ready_o |-> state_q == StIdle)
    else $error("ready outside idle");
  a_no_rdwr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.mem_rd && cmd_o.mem_wr))
    else $error("read and write together");
  a_qa_qb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StQa |=> state_q == StQb)
    else $error("query sequence broken");
`endif
endmodule

FILE: hw/rtl/rmst_datapath.sv
// Datapath: request registers, table memory, build walk counters, result register.
module rmst_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic                             cfg_idx_i,
  input  logic [rmst_pkg::CntW-1:0]        cfg_data_i,
  input  logic [1:0]                       kind_i,
  input  logic [rmst_pkg::RowW-1:0]        row_a_i,
  input  logic [rmst_pkg::ColW-1:0]        col_a_i,
  input  logic [rmst_pkg::RowW-1:0]        row_b_i,
  input  logic [rmst_pkg::ColW-1:0]        col_b_i,
  input  logic [rmst_pkg::ValueWidth-1:0]  element_i,
  input  rmst_pkg::dp_cmd_t                cmd_i,
  output rmst_pkg::dp_sts_t                sts_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [rmst_pkg::ValueWidth-1:0]  max_value_o,
  output logic [1:0]                       status_o
);
  localparam int RowW = rmst_pkg::RowW;
  localparam int ColW = rmst_pkg::ColW;
  localparam int LvlW = rmst_pkg::LvlW;
  localparam int CntW = rmst_pkg::CntW;
  localparam int VW   = rmst_pkg::ValueWidth;

  logic [CntW-1:0] rows_q, cols_q;
  logic [1:0] kind_q;
  logic [RowW-1:0] ra_q, rb_q;
  logic [ColW-1:0] ca_q, cb_q;
  logic [VW-1:0] elem_q;

  function automatic logic [CntW-1:0] clamp(input logic [CntW-1:0] v,
      input logic [CntW-1:0] top);
    if (v == '0) return CntW'(1);
    return (v > top) ? top : v;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= CntW'(rmst_pkg::MaxRows);
      cols_q <= CntW'(rmst_pkg::MaxCols);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == rmst_pkg::CfgRowCount)
        rows_q <= clamp(cfg_data_i, CntW'(rmst_pkg::MaxRows));
      else
        cols_q <= clamp(cfg_data_i, CntW'(rmst_pkg::MaxCols));
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_req) begin
      kind_q <= kind_i;
      ra_q <= row_a_i;
      ca_q <= col_a_i;
      rb_q <= row_b_i;
      cb_q <= col_b_i;
      elem_q <= element_i;
    end
  end

  // Query levels and far corners.
  logic [CntW-1:0] hgt, wid;
  logic [LvlW-1:0] qp, qq;
  logic [RowW-1:0] r2;
  logic [ColW-1:0] c2;
  assign hgt = CntW'(rb_q) - CntW'(ra_q) + CntW'(1);
  assign wid = CntW'(cb_q) - CntW'(ca_q) + CntW'(1);
  assign qp = rmst_pkg::floor_log2(hgt);
  assign qq = rmst_pkg::floor_log2(wid);
  assign r2 = RowW'(CntW'(rb_q) + CntW'(1) - (CntW'(1) << qp));
  assign c2 = ColW'(CntW'(cb_q) + CntW'(1) - (CntW'(1) << qq));

  // Build walk counters.
  logic [LvlW-1:0] wp_q, wq_q;
  logic [RowW-1:0] wi_q;
  logic [ColW-1:0] wj_q;
  logic walk_end_q;
  logic [CntW:0] hsz, wsz;
  logic lvl_bad, lvl_fit, last_i, last_j, last_q;
  assign hsz = (CntW+1)'(1) << wp_q;
  assign wsz = (CntW+1)'(1) << wq_q;
  assign lvl_fit = (hsz <= (CntW+1)'(rows_q)) && (wsz <= (CntW+1)'(cols_q));
  assign lvl_bad = ((wp_q == '0) && (wq_q == '0)) || !lvl_fit;
  assign last_j = !lvl_fit ||
      ((CntW+1)'(wj_q) + wsz >= (CntW+1)'(cols_q));
  assign last_i = !lvl_fit ||
      ((CntW+1)'(wi_q) + hsz >= (CntW+1)'(rows_q));
  assign last_q = wq_q == LvlW'(rmst_pkg::Levels - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; wq_q <= '0; wi_q <= '0; wj_q <= '0; walk_end_q <= 1'b0;
    end else if (cmd_i.walk_init) begin
      wp_q <= '0; wq_q <= '0; wi_q <= '0; wj_q <= '0; walk_end_q <= 1'b0;
    end else if (cmd_i.walk_step) begin
      if (lvl_bad || (last_i && last_j)) begin
        wi_q <= '0;
        wj_q <= '0;
        if (last_q) begin
          wq_q <= '0;
          if (wp_q == LvlW'(rmst_pkg::Levels - 1)) walk_end_q <= 1'b1;
          else wp_q <= wp_q + LvlW'(1);
        end else begin
          wq_q <= wq_q + LvlW'(1);
        end
      end else if (last_j) begin
        wj_q <= '0;
        wi_q <= wi_q + RowW'(1);
      end else begin
        wj_q <= wj_q + ColW'(1);
      end
    end
  end

  // Memory address selection.
  logic [rmst_pkg::AddrW-1:0] addr;
  always_comb begin
    unique case (cmd_i.aop)
      rmst_pkg::AopLoad: addr = rmst_pkg::slot('0, '0, ra_q, ca_q);
      rmst_pkg::AopQuery: begin
        unique case (cmd_i.qsel)
          rmst_pkg::SelQa: addr = rmst_pkg::slot(qp, qq, ra_q, ca_q);
          rmst_pkg::SelQb: addr = rmst_pkg::slot(qp, qq, r2, ca_q);
          rmst_pkg::SelQc: addr = rmst_pkg::slot(qp, qq, ra_q, c2);
          rmst_pkg::SelQd: addr = rmst_pkg::slot(qp, qq, r2, c2);
          default: addr = '0;
        endcase
      end
      rmst_pkg::AopSrcX:
        addr = (wp_q != '0) ? rmst_pkg::slot(wp_q - LvlW'(1), wq_q, wi_q, wj_q)
                            : rmst_pkg::slot(wp_q, wq_q - LvlW'(1), wi_q, wj_q);
      rmst_pkg::AopSrcY:
        addr = (wp_q != '0)
            ? rmst_pkg::slot(wp_q - LvlW'(1), wq_q,
                wi_q + RowW'(hsz >> 1), wj_q)
            : rmst_pkg::slot(wp_q, wq_q - LvlW'(1), wi_q,
                wj_q + ColW'(wsz >> 1));
      rmst_pkg::AopDst: addr = rmst_pkg::slot(wp_q, wq_q, wi_q, wj_q);
      default: addr = '0;
    endcase
  end

  logic [VW-1:0] mem [rmst_pkg::Depth];
  logic [VW-1:0] rd_q, x_q, acc_q, wr_data;
  assign wr_data = (cmd_i.aop == rmst_pkg::AopLoad) ? elem_q
      : (($signed(x_q) > $signed(rd_q)) ? x_q : rd_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr) mem[addr] <= wr_data;
    if (cmd_i.mem_rd) rd_q <= mem[addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_x) x_q <= rd_q;
    if (cmd_i.acc_init) acc_q <= rd_q;
    else if (cmd_i.acc_upd && ($signed(rd_q) > $signed(acc_q))) acc_q <= rd_q;
  end

  // Result register; the last query read folds in on the fly.
  logic out_valid_q;
  logic [VW-1:0] max_q;
  logic [1:0] status_q;
  logic [VW-1:0] fin;
  assign fin = ($signed(rd_q) > $signed(acc_q)) ? rd_q : acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.out_load) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_q <= cmd_i.out_status;
      max_q <= (cmd_i.out_status == rmst_pkg::StatusOk) ? fin : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign max_value_o = max_q;
  assign status_o = status_q;

  assign sts_o.kind = kind_q;
  assign sts_o.load_ok = (CntW'(ra_q) < rows_q) && (CntW'(ca_q) < cols_q);
  assign sts_o.query_ok = (ra_q <= rb_q) && (ca_q <= cb_q) &&
      (CntW'(rb_q) < rows_q) && (CntW'(cb_q) < cols_q);
  assign sts_o.walk_skip = lvl_bad;
  assign sts_o.walk_last = last_i && last_j;
  assign sts_o.walk_done = walk_end_q;

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i && !cmd_i.out_load |=> $stable(max_q))
    else $error("result changed while stalled");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !out_valid_q || out_ready_i)
    else $error("result overwritten");
  a_cfg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rows_q != '0 && cols_q != '0)
    else $error("size register zero");
`endif
endmodule
